FILE: hw/rtl/cais_pkg.sv
// Shared types and byte constants for the comment-aware identifier scanner.
package cais_pkg;

  localparam int OUT_BITS = 24;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic [7:0] ahead_one;
    logic [7:0] ahead_two;
    logic [7:0] ahead_three;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] name_offset;
    logic [OUT_BITS-1:0] name_length;
    logic [OUT_BITS-1:0] line_number;
  } result_t;

  function automatic logic is_first_name(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == CH_USCORE || c == CH_DOLLAR || c == CH_DOT || c == CH_COLON;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

FILE: hw/rtl/cais_in_reg.sv
// Input register holding one accepted word until the scan core takes it.
module cais_in_reg
  import cais_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     take,
  output logic     held_valid,
  output in_word_t held_word
);

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_word <= in_word;
    end
  end

endmodule

FILE: hw/rtl/cais_scan_core.sv
// Scanner state, per-byte update logic and the result register.
module cais_scan_core
  import cais_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     held_valid,
  input  in_word_t held_word,
  output logic     take,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  result
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic                     block_flag, block_flag_next;
  logic                     line_flag, line_flag_next;
  logic [1:0]               skip_remaining, skip_remaining_next;
  logic                     name_open, name_open_next;
  logic [POSITION_BITS-1:0] name_begin, name_begin_next;
  logic                     prev_other, prev_other_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] line_count, line_count_next;
  logic                     text_ended, text_ended_next;
  logic [POSITION_BITS-1:0] line_bumped;

  logic       fire;
  logic       step;
  logic       open_blk, close_blk, first, mid, lc_tmp;
  logic [7:0] c;
  logic [31:0] offset_w, length_w, line_w;

  assign take = !out_valid || !out_stall;
  assign step = held_valid && take;
  assign c    = held_word.text_byte;

  assign open_blk = c == CH_DASH && held_word.ahead_one == CH_DASH &&
                    held_word.ahead_two == CH_LBRK && held_word.ahead_three == CH_LBRK &&
                    !line_flag;
  assign close_blk = c == CH_RBRK && held_word.ahead_one == CH_RBRK;
  assign first     = is_first_name(c);
  assign mid       = first || is_digit(c);

  always_comb begin
    block_flag_next     = block_flag;
    line_flag_next      = line_flag;
    skip_remaining_next = skip_remaining;
    name_open_next      = name_open;
    name_begin_next     = name_begin;
    prev_other_next     = prev_other;
    byte_position_next  = byte_position;
    line_count_next     = line_count;
    text_ended_next     = text_ended;
    line_bumped         = line_count;
    fire                = 1'b0;
    lc_tmp              = line_flag;

    if (!text_ended) begin
      byte_position_next = (byte_position == POS_MAX) ? POS_MAX : byte_position + POS_ONE;
      priority if (c == CH_NUL) begin
        text_ended_next = 1'b1;
      end else if (skip_remaining != 2'd0) begin
        skip_remaining_next = skip_remaining - 2'd1;
      end else if (open_blk) begin
        block_flag_next     = 1'b1;
        skip_remaining_next = 2'd3;
      end else if (close_blk) begin
        block_flag_next     = 1'b0;
        skip_remaining_next = 2'd1;
      end else begin
        if (c == CH_DASH && held_word.ahead_one == CH_DASH) begin
          lc_tmp = 1'b1;
        end
        if (c == CH_LF || c == CH_CR) begin
          lc_tmp = 1'b0;
        end
        line_flag_next = lc_tmp;
        if (c == CH_LF) begin
          line_bumped     = (line_count == POS_MAX) ? POS_MAX : line_count + POS_ONE;
          line_count_next = line_bumped;
        end
        if (!lc_tmp && !block_flag) begin
          if (!name_open) begin
            if (first && prev_other) begin
              name_open_next  = 1'b1;
              name_begin_next = byte_position;
            end
            prev_other_next = !mid;
          end else if (!mid) begin
            fire            = 1'b1;
            name_open_next  = 1'b0;
            prev_other_next = 1'b1;
          end else begin
            prev_other_next = 1'b0;
          end
        end
      end
    end

    // After the last byte of the file, reset the scan state for the next file.
    if (held_word.end_of_text) begin
      block_flag_next     = 1'b0;
      line_flag_next      = 1'b0;
      skip_remaining_next = 2'd0;
      name_open_next      = 1'b0;
      name_begin_next     = '0;
      prev_other_next     = 1'b1;
      byte_position_next  = '0;
      line_count_next     = POS_ONE;
      text_ended_next     = 1'b0;
    end
  end

  assign offset_w = 32'(name_begin);
  assign length_w = 32'(byte_position - name_begin);
  assign line_w   = 32'(line_bumped);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_flag     <= 1'b0;
      line_flag      <= 1'b0;
      skip_remaining <= 2'd0;
      name_open      <= 1'b0;
      name_begin     <= '0;
      prev_other     <= 1'b1;
      byte_position  <= '0;
      line_count     <= POS_ONE;
      text_ended     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (step) begin
        block_flag     <= block_flag_next;
        line_flag      <= line_flag_next;
        skip_remaining <= skip_remaining_next;
        name_open      <= name_open_next;
        name_begin     <= name_begin_next;
        prev_other     <= prev_other_next;
        byte_position  <= byte_position_next;
        line_count     <= line_count_next;
        text_ended     <= text_ended_next;
      end
      if (take) begin
        out_valid <= step && fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && fire) begin
      result.name_offset <= offset_w[OUT_BITS-1:0];
      result.name_length <= length_w[OUT_BITS-1:0];
      result.line_number <= line_w[OUT_BITS-1:0];
    end
  end

endmodule

FILE: hw/rtl/comment_aware_identifier_scanner.sv
// Top level of the comment-aware identifier scanner.
// Each accepted word passes through the input register, then the result register.
// Throughput: one word per cycle while the output is not stalled; the scan
// state loop through the core sets the rate.
// Reset: rst is synchronous, active high; clears all scan state and both
// valid registers. Line count restarts at one, byte position at zero.
module comment_aware_identifier_scanner
  import cais_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel: one text byte plus three bytes of lookahead per word.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic [7:0]  ahead_one,
  input  logic [7:0]  ahead_two,
  input  logic [7:0]  ahead_three,
  input  logic        end_of_text,
  // Output channel: one word per name that ends outside comments.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] name_offset,
  output logic [23:0] name_length,
  output logic [23:0] line_number
);

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     take;
  result_t  result;

  assign in_word.text_byte   = text_byte;
  assign in_word.ahead_one   = ahead_one;
  assign in_word.ahead_two   = ahead_two;
  assign in_word.ahead_three = ahead_three;
  assign in_word.end_of_text = end_of_text;

  // Hold the incoming word; advance whenever the result register can accept.
  cais_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // Comment tracking, name detection and the result register.
  cais_scan_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign name_offset = result.name_offset;
  assign name_length = result.name_length;
  assign line_number = result.line_number;

endmodule

FILE: tb/tb_comment_aware_identifier_scanner.sv
// Self-checking testbench for the comment-aware identifier scanner.
`timescale 1ns / 1ps

module tb_comment_aware_identifier_scanner;
  import cais_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int LONG_HOLD   = 200;        // receiver hold-off, in cycles
  localparam int DRAIN       = 16;         // settle time after the last name word
  localparam int LIMIT       = 1_500_000;  // hard cycle budget for the whole run

  typedef logic [7:0] text_q_t[$];

  // Scoreboard: tracks the scan state of the text seen so far and queues the
  // name words that the scanner owes us.
  class name_scoreboard;
    localparam logic [23:0] POS_TOP = 24'hFFFFFF;

    logic        in_block;
    logic        in_line;
    logic [1:0]  skip_left;
    logic        name_open;
    logic [23:0] name_start;
    logic        prev_other;
    logic [23:0] pos;
    logic [23:0] lines;
    logic        ended;
    int          fails;
    result_t     owed_names[$];

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      in_block   = 1'b0;
      in_line    = 1'b0;
      skip_left  = 2'd0;
      name_open  = 1'b0;
      name_start = '0;
      prev_other = 1'b1;
      pos        = '0;
      lines      = 24'd1;
      ended      = 1'b0;
    endfunction

    function logic [23:0] bump(input logic [23:0] v);
      return (v == POS_TOP) ? v : v + 24'd1;
    endfunction

    function logic lead_char(input logic [7:0] c);
      return (c inside {["A":"Z"], ["a":"z"]}) || c == CH_USCORE || c == CH_DOLLAR ||
             c == CH_DOT || c == CH_COLON;
    endfunction

    // Note one accepted word: advance the scan state, queue a name if it ends.
    function void note_word(input logic [7:0] c, input logic [7:0] a1,
                            input logic [7:0] a2, input logic [7:0] a3,
                            input logic last);
      logic    lead;
      logic    tail;
      result_t r;
      if (!ended) begin
        if (c == CH_NUL) begin
          ended = 1'b1;
        end else if (skip_left != 2'd0) begin
          skip_left = skip_left - 2'd1;
        end else if (c == CH_DASH && a1 == CH_DASH && a2 == CH_LBRK && a3 == CH_LBRK &&
                     !in_line) begin
          in_block  = 1'b1;
          skip_left = 2'd3;
        end else if (c == CH_RBRK && a1 == CH_RBRK) begin
          in_block  = 1'b0;
          skip_left = 2'd1;
        end else begin
          if (c == CH_DASH && a1 == CH_DASH) in_line = 1'b1;
          if (c == CH_LF || c == CH_CR) in_line = 1'b0;
          if (c == CH_LF) lines = bump(lines);
          if (!in_line && !in_block) begin
            lead = lead_char(c);
            tail = lead || (c inside {["0":"9"]});
            if (!name_open) begin
              if (lead && prev_other) begin
                name_open  = 1'b1;
                name_start = pos;
              end
              prev_other = !tail;
            end else if (!tail) begin
              r.name_offset = name_start;
              r.name_length = pos - name_start;
              r.line_number = lines;
              owed_names = {owed_names, r};
              name_open  = 1'b0;
              prev_other = 1'b1;
            end else begin
              prev_other = 1'b0;
            end
          end
        end
        pos = bump(pos);
      end
      if (last) clear();
    endfunction

    // Check one accepted name word against the oldest owed name.
    function void check_result(input logic [23:0] offset, input logic [23:0] length,
                               input logic [23:0] line);
      result_t want;
      if (owed_names.size() == 0) begin
        $error("unexpected name word: offset %0d length %0d line %0d", offset, length, line);
        fails++;
        return;
      end
      want = owed_names.pop_front();
      if (offset !== want.name_offset) begin
        $error("name_offset: expected %0d, actual %0d", want.name_offset, offset);
        fails++;
      end
      if (length !== want.name_length) begin
        $error("name_length: expected %0d, actual %0d", want.name_length, length);
        fails++;
      end
      if (line !== want.line_number) begin
        $error("line_number: expected %0d, actual %0d", want.line_number, line);
        fails++;
      end
    endfunction

    function int pending();
      return owed_names.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'h00;
  logic [7:0]  ahead_one = 8'h00;
  logic [7:0]  ahead_two = 8'h00;
  logic [7:0]  ahead_three = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] name_offset;
  logic [23:0] name_length;
  logic [23:0] line_number;

  name_scoreboard sb;
  int unsigned    cycle_count = 0;
  int             words_sent = 0;
  int             hold_asked = 0;
  int             hold_done = 0;
  bit             no_gaps = 1'b0;

  comment_aware_identifier_scanner i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .ahead_one   (ahead_one),
    .ahead_two   (ahead_two),
    .ahead_three (ahead_three),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .name_offset (name_offset),
    .name_length (name_length),
    .line_number (line_number)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run: count every cycle and give up at the budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Byte at index k of a text, or zero past its end (lookahead padding).
  function automatic logic [7:0] peek(input text_q_t t, input int k);
    return (k < t.size()) ? t[k] : CH_NUL;
  endfunction

  // Append one byte to the end of a text.
  function automatic void add_byte(ref text_q_t t, input logic [7:0] b);
    t = {t, b};
  endfunction

  function automatic text_q_t text_of(input string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
    return q;
  endfunction

  function automatic logic [7:0] lead_pick();
    int r;
    r = $urandom_range(0, 55);
    if (r < 26) return 8'(r) + 8'h41;
    if (r < 52) return 8'(r - 26) + 8'h61;
    case (r)
      52:      return CH_USCORE;
      53:      return CH_DOLLAR;
      54:      return CH_DOT;
      default: return CH_COLON;
    endcase
  endfunction

  // Append one lexical piece of script text: names, markers, line ends, junk.
  function automatic void add_token(ref text_q_t t);
    int n;
    n = $urandom_range(0, 19);
    if (n < 6) begin
      add_byte(t, lead_pick());
      repeat ($urandom_range(0, 8))
        add_byte(t, ($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9)) :
                                                  lead_pick());
    end else if (n < 9) begin
      case ($urandom_range(0, 4))
        0:       add_byte(t, " ");
        1:       add_byte(t, "(");
        2:       add_byte(t, "=");
        3:       add_byte(t, ",");
        default: add_byte(t, 8'h09);
      endcase
    end else begin
      case (n)
        9:  add_byte(t, CH_LF);
        10: add_byte(t, CH_CR);
        11: t = {t, text_of("--[[")};
        12: t = {t, text_of("]]")};
        13: t = {t, text_of("--")};
        14: add_byte(t, 8'($urandom_range(1, 255)));
        15: repeat ($urandom_range(1, 3)) add_byte(t, 8'(8'h30 + $urandom_range(0, 9)));
        16: add_byte(t, CH_DASH);
        17: add_byte(t, $urandom_range(0, 1) ? CH_RBRK : CH_LBRK);
        18: add_byte(t, 8'($urandom_range(128, 255)));
        default: add_byte(t, ($urandom_range(0, 9) == 0) ? CH_NUL : " ");
      endcase
    end
  endfunction

  function automatic text_q_t random_text(input int min_len);
    text_q_t t;
    while (t.size() < min_len) add_token(t);
    return t;
  endfunction

  // Offer one word, hold it until accepted, then note it on the scoreboard.
  task automatic send_word(input logic [7:0] c, input logic [7:0] a1, input logic [7:0] a2,
                           input logic [7:0] a3, input logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= c;
    ahead_one   <= a1;
    ahead_two   <= a2;
    ahead_three <= a3;
    end_of_text <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(c, a1, a2, a3, last);
    words_sent++;
  endtask

  // Stream a text with its lookahead; optionally close the file on its last byte.
  task automatic send_text(input text_q_t t, input bit close_file);
    for (int i = 0; i < t.size(); i++)
      send_word(t[i], peek(t, i + 1), peek(t, i + 2), peek(t, i + 3),
                close_file && i == t.size() - 1);
  endtask

  // Drop valid and hold off until every owed name word has come back.
  task automatic wait_for_names();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Check every name word the scanner hands over.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(name_offset, name_length, line_number);
  end

  // Receiver: random stalls, free-running stretches, and the long hold-off
  // whenever the sender asks for one.
  initial begin : receiver
    int n;
    forever begin
      if (hold_done != hold_asked) begin
        hold_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 100)) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    text_q_t t;
    bit      held;
    bit      paused;
    held   = 1'b0;
    paused = 1'b0;
    sb     = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Name ended by LF; block comment with its passed-over opener; closing
    // bracket pair; a name left open across a line comment and ended by CR;
    // a name cut by the zero terminator and the byte after it ignored.
    t = text_of("A_z9\n--[[q]]b--x\rc");
    add_byte(t, CH_NUL);
    add_byte(t, "d");
    send_text(t, 1'b1);
    // Closing pair outside any comment, then a name ended by a high byte
    // that is also the last byte of the file.
    t = text_of("]]Za0.$:");
    add_byte(t, 8'hFF);
    send_text(t, 1'b1);

    while (words_sent < ITEM_TARGET) begin
      if (!held && words_sent >= 600) begin
        // Stall the output for a long stretch while the input keeps coming.
        held = 1'b1;
        hold_asked++;
        no_gaps = 1'b1;
        repeat (3) send_text(random_text(150), 1'b1);
      end else if (!paused && words_sent >= 1300) begin
        paused = 1'b1;
        wait_for_names();
      end else if ($urandom_range(0, 9) == 0) begin
        // Raw words: arbitrary bytes and lookahead, random file ends.
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 8))
          send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 7) == 0);
      end else begin
        no_gaps = ($urandom_range(0, 4) == 0);
        send_text(random_text($urandom_range(4, 40)), $urandom_range(0, 9) != 0);
      end
    end

    no_gaps = 1'b0;
    wait_for_names();
    repeat (DRAIN) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
